// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, codes and helper functions for the base64 stream decoder.
// Used by every module of the decoder; depends on nothing else.

package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] STATUS_DATA     = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

    localparam logic [6:0] BAD_SEXTET = 7'h40;
    localparam logic [6:0] BAD_MASK   = 7'h40;
    localparam logic [7:0] PAD_CHAR   = 8'h3D;

    localparam logic [2:0] REG_ALLOW_UNPADDED_TAIL = 3'd0;

    typedef struct packed {
        logic [7:0] char_in;
        logic       message_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       group_last;
        logic       message_end;
    } out_word_t;

    // One queued job: up to three results that a single input word causes.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic [1:0]      status;
        logic            msg_end;
    } job_t;

    // Maps a character to its 6-bit value; bit 6 set marks a non-alphabet code.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = BAD_SEXTET;
        if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B) v = 7'd62;
        else if (c == 8'h2F) v = 7'd63;
        return v;
    endfunction

    // Bytes produced by an unpadded tail holding the given number of characters.
    function automatic logic [1:0] tail_bytes(input logic [1:0] held);
        logic [1:0] n;
        unique case (held)
            2'd0: n = 2'd0;
            2'd1: n = 2'd0;
            2'd2: n = 2'd1;
            2'd3: n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
// Front end of the base64 decoder: classifies each character, keeps the group
// state and turns each word into at most one job. Depends on b64d_pkg.

module b64d_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  b64d_pkg::in_word_t word,
    input  logic              allow_tail,
    output logic              push,
    output b64d_pkg::job_t    job
);

    logic [5:0] s0_reg, s1_reg, s2_reg;
    logic [5:0] s0_next, s1_next, s2_next;
    logic [1:0] gc_reg, gc_next;
    logic       pad_reg, pad_next;
    logic       err_reg, err_next;

    logic [6:0] sext;
    logic       is_pad, bad, last;
    logic       fail, emit;
    logic [1:0] fail_status, emit_n;
    logic [5:0] e0, e1, e2, e3;

    assign sext   = b64d_pkg::sextet_of(word.char_in);
    assign bad    = |(sext & b64d_pkg::BAD_MASK);
    assign is_pad = (word.char_in == b64d_pkg::PAD_CHAR);
    assign last   = word.message_last;

    // The incoming value takes the place of the stored one at the current position.
    always_comb
    begin
        e0 = (!is_pad && gc_reg == 2'd0) ? sext[5:0] : s0_reg;
        e1 = (!is_pad && gc_reg == 2'd1) ? sext[5:0] : s1_reg;
        e2 = (!is_pad && gc_reg == 2'd2) ? sext[5:0] : s2_reg;
        e3 = (!is_pad && gc_reg == 2'd3) ? sext[5:0] : 6'd0;
    end

    always_comb
    begin
        fail        = 1'b0;
        fail_status = b64d_pkg::STATUS_BAD_CHAR;
        emit        = 1'b0;
        emit_n      = 2'd0;
        s0_next     = s0_reg;
        s1_next     = s1_reg;
        s2_next     = s2_reg;
        gc_next     = gc_reg;
        pad_next    = pad_reg;
        err_next    = err_reg;

        if (accept)
        begin
            if (err_reg)
            begin
                if (last)
                begin
                    gc_next  = 2'd0;
                    pad_next = 1'b0;
                    err_next = 1'b0;
                end
            end
            else if (is_pad)
            begin
                unique case (gc_reg) inside
                    2'd0, 2'd1: fail = 1'b1;
                    2'd2:
                    begin
                        if (last)
                        begin
                            fail        = 1'b1;
                            fail_status = b64d_pkg::STATUS_BAD_LEN;
                        end
                        else
                        begin
                            pad_next = 1'b1;
                            gc_next  = 2'd3;
                        end
                    end
                    2'd3:
                    begin
                        if (!last)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            emit   = 1'b1;
                            emit_n = pad_reg ? 2'd1 : 2'd2;
                        end
                    end
                    default: fail = 1'b1;
                endcase
            end
            else if (bad || pad_reg)
            begin
                fail = 1'b1;
            end
            else if (gc_reg == 2'd3)
            begin
                emit   = 1'b1;
                emit_n = 2'd3;
            end
            else
            begin
                s0_next = e0;
                s1_next = e1;
                s2_next = e2;
                gc_next = gc_reg + 2'd1;
                if (last)
                begin
                    if (gc_reg == 2'd0 || !allow_tail)
                    begin
                        fail        = 1'b1;
                        fail_status = b64d_pkg::STATUS_BAD_LEN;
                    end
                    else
                    begin
                        emit   = 1'b1;
                        emit_n = b64d_pkg::tail_bytes(gc_reg + 2'd1);
                    end
                end
            end

            if (fail)
            begin
                if (last)
                begin
                    gc_next  = 2'd0;
                    pad_next = 1'b0;
                    err_next = 1'b0;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            if (emit)
            begin
                gc_next  = 2'd0;
                pad_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        push    = fail || emit;
        job.msg_end = fail || last;
        if (fail)
        begin
            job.bytes  = '0;
            job.count  = 2'd1;
            job.status = fail_status;
        end
        else
        begin
            job.bytes[0] = {e0, e1[5:4]};
            job.bytes[1] = {e1[3:0], e2[5:2]};
            job.bytes[2] = {e2[1:0], e3};
            job.count    = emit_n;
            job.status   = b64d_pkg::STATUS_DATA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gc_reg  <= 2'd0;
            pad_reg <= 1'b0;
            err_reg <= 1'b0;
        end
        else
        begin
            gc_reg  <= gc_next;
            pad_reg <= pad_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    // Once an error is latched, the rest of the message produces nothing.
    a_no_job_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !push)
        else $error("job issued while error latched");

    // A pad in the third position always leaves the group at three characters.
    a_pad_count: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg |-> gc_reg == 2'd3)
        else $error("pad flag set with wrong group count");

    // Every data job carries at least one byte.
    a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> job.count != 2'd0)
        else $error("empty job pushed");

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// Short job queue between the decoder front end and the result sequencer.
// Depends on b64d_pkg for the job type.

module b64d_queue
#(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output b64d_pkg::job_t head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::job_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next;
    logic [PW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

    // The front end is held off whenever the queue is full, so no job is lost.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_reg == rd_reg))
        else $error("empty queue with pointers apart");

endmodule

// ===== hw/rtl/b64d_back.sv =====
// Result sequencer of the base64 decoder: steps through the bytes of the job
// at the queue head into an output register. Depends on b64d_pkg.

module b64d_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  b64d_pkg::job_t     head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output b64d_pkg::out_word_t out_word
);

    logic                valid_reg, valid_next;
    b64d_pkg::out_word_t word_reg, word_next;
    logic [1:0]          idx_reg, idx_next;
    logic                load, job_done;
    logic [7:0]          sel_byte;

    assign load     = head_valid && (!valid_reg || !out_stall);
    assign job_done = (idx_reg == head_job.count - 2'd1);
    assign pop      = load && job_done;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head_job.bytes[0];
            2'd1:    sel_byte = head_job.bytes[1];
            2'd2:    sel_byte = head_job.bytes[2];
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next            = 1'b1;
            word_next.out_byte    = sel_byte;
            word_next.status      = head_job.status;
            word_next.group_last  = job_done;
            word_next.message_end = job_done && head_job.msg_end;
            idx_next              = job_done ? 2'd0 : idx_reg + 2'd1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd3)
        else $error("result index out of range");

    // An error result is always the final result of its message and carries a zero byte.
    a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && word_reg.status != b64d_pkg::STATUS_DATA)
            |-> (word_reg.group_last && word_reg.message_end && word_reg.out_byte == 8'd0))
        else $error("error result without end flags");

    a_msg_end_group: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && word_reg.message_end) |-> word_reg.group_last)
        else $error("message end inside a group");

endmodule

// ===== hw/rtl/base64_stream_decoder_unit.sv =====
// Base64 stream decoder: one character word in per cycle while in_stall is low,
// one byte word out per cycle while out_stall is low. The first result of a word
// passes through the job queue and then the output register before it is presented.
// The single output register sets the output rate; the queue absorbs three-byte bursts.
// Reset (rst_n low, asynchronous) empties the queue and output register, clears the
// group state and sets allow_unpadded_tail to 0; no clearing pass follows.

module base64_stream_decoder_unit
#(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  b64d_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output b64d_pkg::out_word_t out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic           allow_reg;
    logic           q_full, q_push, q_pop, q_head_valid;
    logic           in_accept;
    b64d_pkg::job_t q_push_job, q_head_job;
    logic           reg_hit;

    assign pready    = 1'b1;
    assign reg_hit   = ({paddr[2], 2'b00} == b64d_pkg::REG_ALLOW_UNPADDED_TAIL);
    assign prdata    = {31'd0, reg_hit & allow_reg};
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            allow_reg <= pwdata[0];
        end
    end

    b64d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .word       (in_word),
        .allow_tail (allow_reg),
        .push       (q_push),
        .job        (q_push_job)
    );

    b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    b64d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule
